// ===== rtl/core/mex_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
// No dependencies; compile first.
package mex_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int CFG_IDX_BITS = 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } cfg_reg_t;

  localparam word_t MODULUS_RESET  = word_t'(2);
  localparam word_t EXPONENT_RESET = word_t'(1);

endpackage

// ===== rtl/core/mex_if.sv =====
// Channel interfaces for the modular exponentiation block: message input,
// result output and configuration write. Depends on mex_pkg.
interface mex_msg_if;
  import mex_pkg::*;
  logic  valid;
  logic  ready;
  word_t message;
  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface mex_res_if;
  import mex_pkg::*;
  logic  valid;
  logic  ready;
  word_t power_result;
  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

interface mex_cfg_if;
  import mex_pkg::*;
  logic     valid;
  logic     ready;
  cfg_reg_t index;
  word_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: one message word in, message^exponent mod modulus out.
// Depends on mex_pkg and the channel interfaces in mex_if.sv.
//
// Each beat on msg is reduced modulo the modulus, then raised to the configured
// exponent by right-to-left square-and-multiply. All arithmetic runs through
// one shift-and-add modular multiplier that retires one multiplier bit per
// cycle. An item costs one reduction, one square per exponent bit up to the
// highest set bit, and one multiply per set bit; only the reduction runs when
// the exponent is 0, and nothing runs when the modulus is below 2. msg is not
// ready while an item is in work; a finished result waits in an output register,
// so the next item can start before the result is taken. Configuration writes
// are always accepted and must only be made while the block is idle.
module modular_exponentiation (
  input  logic         clk,
  input  logic         rst,
  mex_msg_if.sink      msg,
  mex_res_if.source    res,
  mex_cfg_if.sink      cfg
);
  import mex_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_NEXT, S_DONE} state_t;
  typedef enum logic [1:0] {K_RED, K_ACC, K_SQR} kind_t;

  state_t                state;
  kind_t                 kind;
  word_t                 modulus;
  word_t                 exponent;
  word_t                 exp_sh;
  word_t                 acc;
  word_t                 base;
  word_t                 op_a;
  word_t                 op_b;
  word_t                 part;
  logic [CNT_BITS-1:0]   cnt;
  logic                  res_valid;
  word_t                 res_data;

  // Shared multiplier step: part = 2*part + bit*op_a, reduced below modulus.
  logic [WORD_BITS+1:0]  step_sum;
  logic [WORD_BITS+1:0]  mod1;
  logic [WORD_BITS+1:0]  mod2;
  word_t                 part_next;

  always_comb begin
    mod1     = {2'b00, modulus};
    mod2     = {1'b0, modulus, 1'b0};
    step_sum = {1'b0, part, 1'b0} + (op_b[WORD_BITS-1] ? {2'b00, op_a} : '0);
    priority if (step_sum >= mod2) begin
      part_next = word_t'(step_sum - mod2);
    end else if (step_sum >= mod1) begin
      part_next = word_t'(step_sum - mod1);
    end else begin
      part_next = word_t'(step_sum);
    end
  end

  assign msg.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign res.valid        = res_valid;
  assign res.power_result = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_RED;
      modulus   <= MODULUS_RESET;
      exponent  <= EXPONENT_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MODULUS:  modulus  <= cfg.data;
          REG_EXPONENT: exponent <= cfg.data;
          default:      ;
        endcase
      end

      // S_DONE handles the output register itself
      if (res_valid && res.ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (msg.valid) begin
            exp_sh <= exponent;
            part   <= '0;
            cnt    <= CNT_BITS'(WORD_BITS - 1);
            kind   <= K_RED;
            op_a   <= word_t'(1);
            op_b   <= msg.message;
            if (modulus < word_t'(2)) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              acc   <= word_t'(1);
              state <= S_MUL;
            end
          end
        end

        S_MUL: begin
          part <= part_next;
          op_b <= op_b << 1;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            if (kind == K_ACC) begin
              acc <= part_next;
            end else begin
              base <= part_next;
            end
            state <= S_NEXT;
          end
        end

        S_NEXT: begin
          part <= '0;
          cnt  <= CNT_BITS'(WORD_BITS - 1);
          priority if (kind == K_ACC) begin
            // multiply done for this bit; square the base and move on
            kind   <= K_SQR;
            op_a   <= base;
            op_b   <= base;
            exp_sh <= exp_sh >> 1;
            state  <= S_MUL;
          end else if (exp_sh == '0) begin
            state <= S_DONE;
          end else if (exp_sh[0]) begin
            kind  <= K_ACC;
            op_a  <= base;
            op_b  <= acc;
            state <= S_MUL;
          end else begin
            kind   <= K_SQR;
            op_a   <= base;
            op_b   <= base;
            exp_sh <= exp_sh >> 1;
            state  <= S_MUL;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_data  <= acc;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
